FILE: hdl/csst_pkg.sv
// csst_pkg: shared types, widths, datapath opcodes and the move packing helper
// for the constant-speed step-to-target block; no dependencies

package csst_pkg;

  // coordinate width and derived internal widths
  localparam int COORD_BITS = 32;
  localparam int N_BITS     = COORD_BITS + 1;
  localparam int W_BITS     = 2 * N_BITS;
  localparam int CNT_BITS   = $clog2(N_BITS + 1);

  // one input item
  typedef struct packed {
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] target_x;
    logic signed [COORD_BITS-1:0] target_y;
    logic [COORD_BITS-2:0]        speed;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic signed [COORD_BITS-1:0] move_x;
    logic signed [COORD_BITS-1:0] move_y;
    logic                         arrived;
  } out_item_t;

  // datapath operations
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_MUL_STEP,
    DP_SQRT_INIT,
    DP_SQRT_STEP,
    DP_SCALE_INIT,
    DP_DIV_INIT,
    DP_DIV_STEP,
    DP_STEP_INIT,
    DP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic arrived;
  } dp_sts_t;

  // signed magnitude to saturated two's complement coordinate
  function automatic logic [COORD_BITS-1:0] pack_move(input logic neg,
                                                      input logic [N_BITS-1:0] m);
    logic [N_BITS-1:0] lim;
    logic [N_BITS-1:0] v;
    lim = N_BITS'(1) << (COORD_BITS - 1);
    if (neg) begin
      v = (m > lim) ? lim : m;
      v = ~v + N_BITS'(1);
    end else begin
      v = (m > lim - N_BITS'(1)) ? lim - N_BITS'(1) : m;
    end
    return v[COORD_BITS-1:0];
  endfunction

endpackage

FILE: hdl/csst_datapath.sv
// csst_datapath: two-lane shift-add multipliers, restoring square root and
// restoring dividers, carried distance register and result register; uses csst_pkg

module csst_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  csst_pkg::in_item_t  in_data,
  input  csst_pkg::dp_cmd_t   cmd,
  output csst_pkg::dp_sts_t   sts,
  output csst_pkg::out_item_t out_data
);

  localparam int C = csst_pkg::COORD_BITS;
  localparam int N = csst_pkg::N_BITS;
  localparam int W = csst_pkg::W_BITS;

  logic [N-1:0] ax_r [2];
  logic         neg_r [2];
  logic [N-1:0] d_r;
  logic         arrived_r;
  logic [W-1:0] acc_r [2];
  logic [W-1:0] mcand_r [2];
  logic [N-1:0] mplier_r [2];
  logic [N-1:0] s_r [2];
  logic [W-1:0] rad_r;
  logic [N:0]   rem_r;
  logic [N-1:0] root_r;
  logic [N-1:0] carried_r;
  csst_pkg::out_item_t out_r;

  logic [N-1:0] dif [2];
  logic [N-1:0] mag_in [2];
  logic [N:0]   d_sum;
  logic [N-1:0] d_sat;
  logic         arrived_in;
  logic [W-1:0] acc_add [2];
  logic [N:0]   div_t [2];
  logic         div_ge [2];
  logic [N:0]   div_rem [2];
  logic [N-1:0] clamp_s [2];
  logic [N+2:0] sq_rem2;
  logic [N+2:0] sq_trial;
  logic         sq_ge;
  logic [N+2:0] sq_rem_new;
  logic [N-1:0] carried_fin;

  // input differences, magnitudes and intended distance
  always_comb begin
    dif[0] = {in_data.target_x[C-1], in_data.target_x} - {in_data.pos_x[C-1], in_data.pos_x};
    dif[1] = {in_data.target_y[C-1], in_data.target_y} - {in_data.pos_y[C-1], in_data.pos_y};
    for (int i = 0; i < 2; i++) begin
      mag_in[i] = dif[i][N-1] ? (~dif[i] + N'(1)) : dif[i];
    end
    arrived_in = (dif[0] == '0) && (dif[1] == '0);
    d_sum = {1'b0, carried_r} + (N+1)'(in_data.speed);
    d_sat = d_sum[N] ? '1 : d_sum[N-1:0];
  end

  // per-lane multiply, divide and clamp steps
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      acc_add[i] = acc_r[i] + (mplier_r[i][0] ? mcand_r[i] : '0);
      div_t[i]   = {acc_r[i][W-1:N], acc_r[i][N-1]};
      div_ge[i]  = div_t[i] >= {1'b0, root_r};
      div_rem[i] = div_ge[i] ? (div_t[i] - {1'b0, root_r}) : div_t[i];
      clamp_s[i] = (acc_r[i][N-1:0] < ax_r[i]) ? acc_r[i][N-1:0] : ax_r[i];
    end
  end

  // square root step, two radicand bits per cycle
  always_comb begin
    sq_rem2    = {rem_r, rad_r[W-1:W-2]};
    sq_trial   = {1'b0, root_r, 2'b01};
    sq_ge      = sq_rem2 >= sq_trial;
    sq_rem_new = sq_ge ? (sq_rem2 - sq_trial) : sq_rem2;
  end

  // distance left over after the move
  always_comb begin
    carried_fin = (d_r > root_r) ? (d_r - root_r) : '0;
  end

  // carried distance, cleared on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carried_r <= '0;
    end else if (cmd.op == csst_pkg::DP_FINISH) begin
      carried_r <= arrived_r ? '0 : carried_fin;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      csst_pkg::DP_LOAD: begin
        arrived_r <= arrived_in;
        d_r       <= d_sat;
        for (int i = 0; i < 2; i++) begin
          ax_r[i]     <= mag_in[i];
          neg_r[i]    <= dif[i][N-1];
          acc_r[i]    <= '0;
          mcand_r[i]  <= W'(mag_in[i]);
          mplier_r[i] <= mag_in[i];
        end
      end
      csst_pkg::DP_MUL_STEP: begin
        for (int i = 0; i < 2; i++) begin
          acc_r[i]    <= acc_add[i];
          mcand_r[i]  <= mcand_r[i] << 1;
          mplier_r[i] <= mplier_r[i] >> 1;
        end
      end
      csst_pkg::DP_SQRT_INIT: begin
        rad_r  <= acc_r[0] + acc_r[1];
        rem_r  <= '0;
        root_r <= '0;
      end
      csst_pkg::DP_SQRT_STEP: begin
        rad_r  <= rad_r << 2;
        rem_r  <= sq_rem_new[N:0];
        root_r <= {root_r[N-2:0], sq_ge};
      end
      csst_pkg::DP_SCALE_INIT: begin
        for (int i = 0; i < 2; i++) begin
          acc_r[i]    <= '0;
          mcand_r[i]  <= W'(ax_r[i]);
          mplier_r[i] <= d_r;
        end
      end
      csst_pkg::DP_DIV_INIT: begin
        // quotient bits shift in at the bottom of the accumulator
      end
      csst_pkg::DP_DIV_STEP: begin
        for (int i = 0; i < 2; i++) begin
          acc_r[i] <= {div_rem[i][N-1:0], acc_r[i][N-2:0], div_ge[i]};
        end
      end
      csst_pkg::DP_STEP_INIT: begin
        for (int i = 0; i < 2; i++) begin
          s_r[i]      <= clamp_s[i];
          acc_r[i]    <= '0;
          mcand_r[i]  <= W'(clamp_s[i]);
          mplier_r[i] <= clamp_s[i];
        end
      end
      csst_pkg::DP_FINISH: begin
        out_r.arrived <= arrived_r;
        out_r.move_x  <= arrived_r ? '0 : csst_pkg::pack_move(neg_r[0], s_r[0]);
        out_r.move_y  <= arrived_r ? '0 : csst_pkg::pack_move(neg_r[1], s_r[1]);
      end
      default: begin
      end
    endcase
  end

  assign sts.arrived = arrived_r;
  assign out_data    = out_r;

endmodule

FILE: hdl/csst_ctrl.sv
// csst_ctrl: sequencer for one item at a time, phase counter and result valid;
// drives datapath opcodes from csst_pkg

module csst_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output csst_pkg::dp_cmd_t cmd,
  input  csst_pkg::dp_sts_t sts
);

  localparam int CB = csst_pkg::CNT_BITS;
  localparam logic [CB-1:0] CNT_LAST = CB'(csst_pkg::N_BITS);

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_MUL_SQ    = 8'b0000_0010,
    S_SQRT_LEN  = 8'b0000_0100,
    S_MUL_SCALE = 8'b0000_1000,
    S_DIV       = 8'b0001_0000,
    S_MUL_STEP  = 8'b0010_0000,
    S_SQRT_TRAV = 8'b0100_0000,
    S_DONE      = 8'b1000_0000
  } state_t;

  state_t        state_r, state_nxt;
  logic [CB-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          last;

  assign last = (cnt_r == CNT_LAST);

  // next state, phase count and opcode
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd.op    = csst_pkg::DP_NOP;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = csst_pkg::DP_LOAD;
          state_nxt = S_MUL_SQ;
          cnt_nxt   = '0;
        end
      end
      S_MUL_SQ: begin
        priority if (sts.arrived) begin
          state_nxt = S_DONE;
        end else if (last) begin
          cmd.op    = csst_pkg::DP_SQRT_INIT;
          state_nxt = S_SQRT_LEN;
          cnt_nxt   = '0;
        end else begin
          cmd.op  = csst_pkg::DP_MUL_STEP;
          cnt_nxt = cnt_r + CB'(1);
        end
      end
      S_SQRT_LEN: begin
        if (last) begin
          cmd.op    = csst_pkg::DP_SCALE_INIT;
          state_nxt = S_MUL_SCALE;
          cnt_nxt   = '0;
        end else begin
          cmd.op  = csst_pkg::DP_SQRT_STEP;
          cnt_nxt = cnt_r + CB'(1);
        end
      end
      S_MUL_SCALE: begin
        if (last) begin
          cmd.op    = csst_pkg::DP_DIV_INIT;
          state_nxt = S_DIV;
          cnt_nxt   = '0;
        end else begin
          cmd.op  = csst_pkg::DP_MUL_STEP;
          cnt_nxt = cnt_r + CB'(1);
        end
      end
      S_DIV: begin
        if (last) begin
          cmd.op    = csst_pkg::DP_STEP_INIT;
          state_nxt = S_MUL_STEP;
          cnt_nxt   = '0;
        end else begin
          cmd.op  = csst_pkg::DP_DIV_STEP;
          cnt_nxt = cnt_r + CB'(1);
        end
      end
      S_MUL_STEP: begin
        if (last) begin
          cmd.op    = csst_pkg::DP_SQRT_INIT;
          state_nxt = S_SQRT_TRAV;
          cnt_nxt   = '0;
        end else begin
          cmd.op  = csst_pkg::DP_MUL_STEP;
          cnt_nxt = cnt_r + CB'(1);
        end
      end
      S_SQRT_TRAV: begin
        if (last) begin
          state_nxt = S_DONE;
          cnt_nxt   = '0;
        end else begin
          cmd.op  = csst_pkg::DP_SQRT_STEP;
          cnt_nxt = cnt_r + CB'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.op    = csst_pkg::DP_FINISH;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result valid: set on finish, cleared on transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.op == csst_pkg::DP_FINISH) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // an accepted transfer starts the first multiply phase
  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == S_MUL_SQ)
    else $error("accepted item did not start processing");

  // phase counter stays within one phase
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_LAST)
    else $error("phase counter out of range");

  // a new result only comes from the done state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result valid raised outside done state");

endmodule

FILE: hdl/constant_speed_step_to_target.sv
// constant_speed_step_to_target: one item at a time through shared bit-serial units.
// Arrived item: S_MUL_SQ goes straight to S_DONE, whose finish registers the result and
// sets result valid. Other items first run three 33-step multiply phases, two 33-step
// square roots and a 33-step divide. Next item is taken once the result sits in the output
// register. Synchronous active-low reset clears the sequencer, result valid and the carried
// distance. Depends on csst_pkg, csst_ctrl and csst_datapath.

module constant_speed_step_to_target (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  csst_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output csst_pkg::out_item_t out_data
);

  csst_pkg::dp_cmd_t cmd;
  csst_pkg::dp_sts_t sts;

  // sequencer
  csst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // arithmetic
  csst_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule
